[design/usmg_pkg.sv]
package usmg_pkg;

   localparam int MAX_STACKS      = 256;
   localparam int MAX_SECTORS     = 256;
   localparam int SINE_TABLE_BITS = 10;

   localparam int TURN    = 1 << SINE_TABLE_BITS;
   localparam int QUART   = TURN / 4;
   localparam int PHASE_W = SINE_TABLE_BITS;

   localparam int COUNT_W  = 9;
   localparam int RADIUS_W = 16;
   localparam int NORM_W   = 16;
   localparam int POS_W    = 17;
   localparam int IDX_W    = 17;
   localparam int TEX_W    = 16;
   localparam int CSR_W    = 16;

   // quotient of the grid fraction, 16 fraction bits plus the whole bit
   localparam int FRAC_W       = 16;
   localparam int QUO_W        = FRAC_W + 1;
   localparam int DIV_STEPS_A  = 6;
   localparam int DIV_STEPS_B  = FRAC_W - 2 * DIV_STEPS_A;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   typedef enum logic [1:0] {
      CSR_RADIUS       = 2'd0,
      CSR_SECTOR_COUNT = 2'd1,
      CSR_STACK_COUNT  = 2'd2
   } csr_index_type;

   // divider state carried down the front pipeline
   typedef struct packed {
      logic [COUNT_W-1:0] st;
      logic [COUNT_W-1:0] se;
      logic [COUNT_W-1:0] stacks;
      logic [COUNT_W-1:0] sectors;
      logic [COUNT_W-1:0] rem_f;
      logic [COUNT_W-1:0] rem_g;
      logic [QUO_W-1:0]   quo_f;
      logic [QUO_W-1:0]   quo_g;
      logic [IDX_W-1:0]   k1;
      logic               has_up;
      logic               has_lo;
   } usmg_div_type;

   // one classified grid point, as queued for the back end
   typedef struct packed {
      logic [PHASE_W-1:0] pphi;
      logic [PHASE_W-1:0] pth;
      logic [TEX_W-1:0]   u;
      logic [TEX_W-1:0]   v;
      logic [IDX_W-1:0]   k1;
      logic [IDX_W-1:0]   k2;
      logic               has_up;
      logic               has_lo;
   } usmg_entry_type;

   typedef logic [14:0] sine_table_type [0:QUART];
   typedef longint unsigned taylor_div_type [1:7];

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam taylor_div_type TAYLOR_DIV = '{6, 20, 42, 72, 110, 156, 210};

   // quarter wave, taylor series in q30
   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] r;
      longint s;
      for (int i = 0; i <= QUART; i++) begin
         x    = (64'(i) * HALF_PI_Q30 + 64'(QUART / 2)) / 64'(QUART);
         x2   = (x * x + (64'd1 << 29)) >> 30;
         term = x;
         s    = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2 + (64'd1 << 29)) >> 30) / TAYLOR_DIV[k];
            if ((k & 1) == 1) begin
               s = s - longint'(term);
            end else begin
               s = s + longint'(term);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         r = (64'(s) + (64'd1 << 14)) >> 15;
         if (r > 64'd32767) begin
            r = 64'd32767;
         end
         t[i] = r[14:0];
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   function automatic logic signed [NORM_W-1:0] sin_at(input logic [PHASE_W-1:0] p);
      logic [1:0]         q;
      logic [PHASE_W-3:0] idx;
      logic [PHASE_W-2:0] j;
      logic [14:0]        m;
      q   = p[PHASE_W-1 -: 2];
      idx = p[PHASE_W-3:0];
      j   = q[0] ? (PHASE_W-1)'(QUART) - {1'b0, idx} : {1'b0, idx};
      m   = SINE_TABLE[j];
      return q[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   function automatic logic signed [NORM_W-1:0] cos_at(input logic [PHASE_W-1:0] p);
      return sin_at(p + PHASE_W'(QUART));
   endfunction

   // shift right by 15, halves away from zero
   function automatic logic signed [18:0] round_q15(input logic signed [33:0] v);
      logic [33:0] mag;
      logic [33:0] r;
      mag = v[33] ? 34'(-v) : 34'(v);
      r   = (mag + 34'(1 << 14)) >> 15;
      return v[33] ? -$signed(19'(r)) : $signed(19'(r));
   endfunction

endpackage

[design/uv_sphere_mesh_generator.sv]
// channel   ports                                   transfer
// request   start, busy, req_stack_pos/sector_pos   start high while busy low
// response  rsp_valid, rsp_kind .. rsp_corner_c     every cycle rsp_valid is high
// csr       csr_write, csr_index, csr_data          every cycle csr_write is high
//
// each transaction gives a vertex and up to two triangles, one per cycle, so
// the response port sets the sustained rate. the vertex passes the front
// pipeline, the queue, back stages a and b and the result stage. reset clears
// the pipelines and queue and loads radius 1.0 and 16 by 16. the response side
// cannot stall; busy rises only when the queue and the front pipeline together
// hold eight points.
module uv_sphere_mesh_generator
   import usmg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [COUNT_W-1:0]         req_stack_pos,
   input  logic [COUNT_W-1:0]         req_sector_pos,
   input  logic                       csr_write,
   input  logic [1:0]                 csr_index,
   input  logic [CSR_W-1:0]           csr_data,
   output logic                       rsp_valid,
   output logic                       rsp_kind,
   output logic                       rsp_last,
   output logic signed [POS_W-1:0]    rsp_pos_x,
   output logic signed [POS_W-1:0]    rsp_pos_y,
   output logic signed [POS_W-1:0]    rsp_pos_z,
   output logic signed [NORM_W-1:0]   rsp_norm_x,
   output logic signed [NORM_W-1:0]   rsp_norm_y,
   output logic signed [NORM_W-1:0]   rsp_norm_z,
   output logic [2*TEX_W-1:0]         rsp_tex_uv,
   output logic [IDX_W-1:0]           rsp_corner_a,
   output logic [IDX_W-1:0]           rsp_corner_b,
   output logic [IDX_W-1:0]           rsp_corner_c
);

   // configuration registers
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [COUNT_W-1:0]  sector_count_ff, sector_count_in;
   logic [COUNT_W-1:0]  stack_count_ff, stack_count_in;

   logic                accept;
   logic                push, pop, empty;
   usmg_entry_type      push_entry, head;
   logic [2:0]          in_flight;
   logic [QUEUE_AW:0]   q_count;
   logic [QUEUE_AW+1:0] occupancy;

   always_comb begin
      radius_in       = radius_ff;
      sector_count_in = sector_count_ff;
      stack_count_in  = stack_count_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RADIUS:       radius_in       = csr_data[RADIUS_W-1:0];
            CSR_SECTOR_COUNT: sector_count_in = csr_data[COUNT_W-1:0];
            CSR_STACK_COUNT:  stack_count_in  = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff       <= RADIUS_W'(256);
         sector_count_ff <= COUNT_W'(16);
         stack_count_ff  <= COUNT_W'(16);
      end else begin
         radius_ff       <= radius_in;
         sector_count_ff <= sector_count_in;
         stack_count_ff  <= stack_count_in;
      end
   end

   // room is reserved for everything still in the front pipeline
   assign occupancy = (QUEUE_AW+2)'(q_count) + (QUEUE_AW+2)'(in_flight);
   assign busy      = (occupancy >= (QUEUE_AW+2)'(QUEUE_DEPTH));
   assign accept    = start && !busy;

   usmg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .stack_pos    (req_stack_pos),
      .sector_pos   (req_sector_pos),
      .stack_count  (stack_count_ff),
      .sector_count (sector_count_ff),
      .push         (push),
      .push_entry   (push_entry),
      .in_flight    (in_flight)
   );

   usmg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .count      (q_count)
   );

   usmg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (empty),
      .pop          (pop),
      .radius       (radius_ff),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last),
      .rsp_pos_x    (rsp_pos_x),
      .rsp_pos_y    (rsp_pos_y),
      .rsp_pos_z    (rsp_pos_z),
      .rsp_norm_x   (rsp_norm_x),
      .rsp_norm_y   (rsp_norm_y),
      .rsp_norm_z   (rsp_norm_z),
      .rsp_tex_uv   (rsp_tex_uv),
      .rsp_corner_a (rsp_corner_a),
      .rsp_corner_b (rsp_corner_b),
      .rsp_corner_c (rsp_corner_c)
   );

endmodule

[design/usmg_front.sv]
module usmg_front
   import usmg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [COUNT_W-1:0]   stack_pos,
   input  logic [COUNT_W-1:0]   sector_pos,
   input  logic [COUNT_W-1:0]   stack_count,
   input  logic [COUNT_W-1:0]   sector_count,
   output logic                 push,
   output usmg_entry_type       push_entry,
   output logic [2:0]           in_flight
);

   logic [3:0]         valid_ff;
   logic [3:0]         valid_in;
   usmg_div_type       s0_ff, s1_ff, s2_ff, s3_ff;
   usmg_div_type       s0_in, s1_in, s2_in, s3_in;
   logic [COUNT_W-1:0] stacks, sectors, st, se;
   logic               in_grid;
   logic [QUO_W:0]     f_ext, g_ext;
   logic [QUO_W:0]     pphi_w, pth_w, u_w, v_w;

   function automatic usmg_div_type div_steps(input usmg_div_type s, input int n);
      usmg_div_type o;
      logic [COUNT_W:0] r2;
      o = s;
      for (int i = 0; i < DIV_STEPS_A; i++) begin
         if (i < n) begin
            r2 = {o.rem_f, 1'b0};
            if (r2 >= {1'b0, o.stacks}) begin
               o.rem_f = COUNT_W'(r2 - {1'b0, o.stacks});
               o.quo_f = {o.quo_f[QUO_W-2:0], 1'b1};
            end else begin
               o.rem_f = r2[COUNT_W-1:0];
               o.quo_f = {o.quo_f[QUO_W-2:0], 1'b0};
            end
            r2 = {o.rem_g, 1'b0};
            if (r2 >= {1'b0, o.sectors}) begin
               o.rem_g = COUNT_W'(r2 - {1'b0, o.sectors});
               o.quo_g = {o.quo_g[QUO_W-2:0], 1'b1};
            end else begin
               o.rem_g = r2[COUNT_W-1:0];
               o.quo_g = {o.quo_g[QUO_W-2:0], 1'b0};
            end
         end
      end
      return o;
   endfunction

   // clamp counts and point, classify the grid cell
   always_comb begin
      stacks  = (stack_count == '0) ? COUNT_W'(1) :
                (stack_count > COUNT_W'(MAX_STACKS)) ? COUNT_W'(MAX_STACKS) : stack_count;
      sectors = (sector_count == '0) ? COUNT_W'(1) :
                (sector_count > COUNT_W'(MAX_SECTORS)) ? COUNT_W'(MAX_SECTORS) : sector_count;
      st      = (stack_pos > stacks) ? stacks : stack_pos;
      se      = (sector_pos > sectors) ? sectors : sector_pos;
      in_grid = (st < stacks) && (se < sectors);

      s0_in         = '0;
      s0_in.st      = st;
      s0_in.se      = se;
      s0_in.stacks  = stacks;
      s0_in.sectors = sectors;
      s0_in.quo_f   = QUO_W'(st == stacks);
      s0_in.quo_g   = QUO_W'(se == sectors);
      s0_in.rem_f   = (st == stacks) ? '0 : st;
      s0_in.rem_g   = (se == sectors) ? '0 : se;
      s0_in.has_up  = in_grid && (st != '0);
      s0_in.has_lo  = in_grid && (st != COUNT_W'(stacks - COUNT_W'(1)));
   end

   always_comb begin
      s1_in    = div_steps(s0_ff, DIV_STEPS_A);
      s1_in.k1 = IDX_W'(s0_ff.st) * (IDX_W'(s0_ff.sectors) + IDX_W'(1)) + IDX_W'(s0_ff.se);
      s2_in    = div_steps(s1_ff, DIV_STEPS_A);
      s3_in    = div_steps(s2_ff, DIV_STEPS_B);
   end

   assign valid_in = {valid_ff[2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   // rounded phases and texture coordinates from the quotients
   always_comb begin
      f_ext  = {1'b0, s3_ff.quo_f};
      g_ext  = {1'b0, s3_ff.quo_g};
      pphi_w = ((f_ext >> (FRAC_W - SINE_TABLE_BITS)) + (QUO_W+1)'(1)) >> 1;
      pth_w  = ((g_ext >> (FRAC_W - 1 - SINE_TABLE_BITS)) + (QUO_W+1)'(1)) >> 1;
      v_w    = (f_ext + (QUO_W+1)'(1)) >> 1;
      u_w    = (g_ext + (QUO_W+1)'(1)) >> 1;

      push_entry.pphi   = pphi_w[PHASE_W-1:0];
      push_entry.pth    = pth_w[PHASE_W-1:0];
      push_entry.u      = u_w[TEX_W-1:0];
      push_entry.v      = v_w[TEX_W-1:0];
      push_entry.k1     = s3_ff.k1;
      push_entry.k2     = s3_ff.k1 + IDX_W'(s3_ff.sectors) + IDX_W'(1);
      push_entry.has_up = s3_ff.has_up;
      push_entry.has_lo = s3_ff.has_lo;
   end

   assign push      = valid_ff[3];
   assign in_flight = 3'($countones(valid_ff));

endmodule

[design/usmg_queue.sv]
module usmg_queue
   import usmg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  usmg_entry_type      push_entry,
   input  logic                pop,
   output usmg_entry_type      head,
   output logic                empty,
   output logic [QUEUE_AW:0]   count
);

   usmg_entry_type      mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

[design/usmg_back.sv]
module usmg_back
   import usmg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  usmg_entry_type             head,
   input  logic                       empty,
   output logic                       pop,
   input  logic [RADIUS_W-1:0]        radius,
   output logic                       rsp_valid,
   output logic                       rsp_kind,
   output logic                       rsp_last,
   output logic signed [POS_W-1:0]    rsp_pos_x,
   output logic signed [POS_W-1:0]    rsp_pos_y,
   output logic signed [POS_W-1:0]    rsp_pos_z,
   output logic signed [NORM_W-1:0]   rsp_norm_x,
   output logic signed [NORM_W-1:0]   rsp_norm_y,
   output logic signed [NORM_W-1:0]   rsp_norm_z,
   output logic [2*TEX_W-1:0]         rsp_tex_uv,
   output logic [IDX_W-1:0]           rsp_corner_a,
   output logic [IDX_W-1:0]           rsp_corner_b,
   output logic [IDX_W-1:0]           rsp_corner_c
);

   // stage a: table lookups
   logic                      va_ff, va_in;
   usmg_entry_type            ea_ff;
   logic signed [NORM_W-1:0]  ny_a_ff, rr_a_ff, cth_a_ff, sth_a_ff;
   // stage b: normals
   logic                      vb_ff, vb_in;
   usmg_entry_type            eb_ff;
   logic signed [NORM_W-1:0]  nx_b_ff, ny_b_ff, nz_b_ff;
   logic signed [NORM_W-1:0]  nx_b_in, nz_b_in;
   // result stage
   logic                      hold_ff, hold_in;
   logic [1:0]                phase_ff, phase_in;
   logic [1:0]                last_ff, last_in;
   usmg_entry_type            ee_ff;
   logic signed [NORM_W-1:0]  nx_e_ff, ny_e_ff, nz_e_ff;
   logic signed [POS_W-1:0]   px_e_ff, py_e_ff, pz_e_ff;
   logic signed [POS_W-1:0]   px_e_in, py_e_in, pz_e_in;

   logic                      free, en;
   logic signed [RADIUS_W:0]  rad;
   logic signed [18:0]        rnd_x, rnd_y, rnd_z, rnd_nx, rnd_nz;
   logic                      upper;

   assign free = !hold_ff || (phase_ff == last_ff);
   assign en   = !(vb_ff && !free);
   assign pop  = en && !empty;

   always_comb begin
      va_in   = en ? pop : va_ff;
      vb_in   = en ? va_ff : vb_ff;
      hold_in = free ? vb_ff : hold_ff;
      if (free) begin
         phase_in = '0;
         last_in  = 2'(eb_ff.has_up) + 2'(eb_ff.has_lo);
      end else begin
         phase_in = phase_ff + 2'd1;
         last_in  = last_ff;
      end
   end

   always_comb begin
      rnd_nx  = round_q15(34'($signed(rr_a_ff) * $signed(cth_a_ff)));
      rnd_nz  = round_q15(34'($signed(rr_a_ff) * $signed(sth_a_ff)));
      nx_b_in = rnd_nx[NORM_W-1:0];
      nz_b_in = rnd_nz[NORM_W-1:0];
      rad     = $signed({1'b0, radius});
      rnd_x   = round_q15(34'(rad * nx_b_ff));
      rnd_y   = round_q15(34'(rad * ny_b_ff));
      rnd_z   = round_q15(34'(rad * nz_b_ff));
      px_e_in = rnd_x[POS_W-1:0];
      py_e_in = rnd_y[POS_W-1:0];
      pz_e_in = rnd_z[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         hold_ff  <= 1'b0;
         phase_ff <= '0;
         last_ff  <= '0;
      end else begin
         va_ff    <= va_in;
         vb_ff    <= vb_in;
         hold_ff  <= hold_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
      end
      if (en) begin
         ea_ff    <= head;
         ny_a_ff  <= cos_at(head.pphi);
         rr_a_ff  <= sin_at(head.pphi);
         cth_a_ff <= cos_at(head.pth);
         sth_a_ff <= sin_at(head.pth);
         eb_ff    <= ea_ff;
         nx_b_ff  <= nx_b_in;
         ny_b_ff  <= ny_a_ff;
         nz_b_ff  <= nz_b_in;
      end
      if (free) begin
         ee_ff   <= eb_ff;
         nx_e_ff <= nx_b_ff;
         ny_e_ff <= ny_b_ff;
         nz_e_ff <= nz_b_ff;
         px_e_ff <= px_e_in;
         py_e_ff <= py_e_in;
         pz_e_ff <= pz_e_in;
      end
   end

   // vertex first, then upper and lower triangles
   always_comb begin
      upper        = (phase_ff == 2'd1) && ee_ff.has_up;
      rsp_valid    = hold_ff;
      rsp_last     = (phase_ff == last_ff);
      rsp_kind     = KIND_TRIANGLE;
      rsp_pos_x    = '0;
      rsp_pos_y    = '0;
      rsp_pos_z    = '0;
      rsp_norm_x   = '0;
      rsp_norm_y   = '0;
      rsp_norm_z   = '0;
      rsp_tex_uv   = '0;
      rsp_corner_a = '0;
      rsp_corner_b = '0;
      rsp_corner_c = '0;
      if (phase_ff == '0) begin
         rsp_kind   = KIND_VERTEX;
         rsp_pos_x  = px_e_ff;
         rsp_pos_y  = py_e_ff;
         rsp_pos_z  = pz_e_ff;
         rsp_norm_x = nx_e_ff;
         rsp_norm_y = ny_e_ff;
         rsp_norm_z = nz_e_ff;
         rsp_tex_uv = {ee_ff.u, ee_ff.v};
      end else if (upper) begin
         rsp_corner_a = ee_ff.k1;
         rsp_corner_b = ee_ff.k2;
         rsp_corner_c = ee_ff.k1 + IDX_W'(1);
      end else begin
         rsp_corner_a = ee_ff.k1 + IDX_W'(1);
         rsp_corner_b = ee_ff.k2;
         rsp_corner_c = ee_ff.k2 + IDX_W'(1);
      end
   end

endmodule

[sim/tb_uv_sphere_mesh_generator.sv]
`timescale 1ns / 1ps

// one result as seen on the response port
typedef struct {
   logic        kind;
   logic        last;
   logic [16:0] pos_x;
   logic [16:0] pos_y;
   logic [16:0] pos_z;
   logic [15:0] norm_x;
   logic [15:0] norm_y;
   logic [15:0] norm_z;
   logic [31:0] tex_uv;
   logic [16:0] corner_a;
   logic [16:0] corner_b;
   logic [16:0] corner_c;
} mesh_result_type;

class mesh_scoreboard;
   localparam int PHASE_STEPS = 1024;
   localparam int QUARTER     = 256;

   longint          sine_q [0:QUARTER];
   longint          radius_q88;
   longint          sector_reg;
   longint          stack_reg;
   mesh_result_type pending_results [$];
   int              error_count;

   function new();
      longint unsigned x, x2, term, r;
      longint          acc;
      longint unsigned divs [1:7] = '{6, 20, 42, 72, 110, 156, 210};
      for (int i = 0; i <= QUARTER; i++) begin
         x   = (longint'(i) * 64'd1686629713 + QUARTER / 2) / QUARTER;
         x2  = (x * x + (64'd1 << 29)) >> 30;
         term = x;
         acc = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2 + (64'd1 << 29)) >> 30) / divs[k];
            acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
         end
         if (acc < 0) begin
            acc = 0;
         end
         r = (longint'(acc) + (64'd1 << 14)) >> 15;
         sine_q[i] = (r > 32767) ? 32767 : longint'(r);
      end
      radius_q88 = 256;
      sector_reg = 16;
      stack_reg  = 16;
      error_count = 0;
   endfunction

   function void set_reg(int idx, longint val);
      case (idx)
         0: begin
            radius_q88 = val & 16'hFFFF;
         end
         1: begin
            sector_reg = val & 9'h1FF;
         end
         2: begin
            stack_reg = val & 9'h1FF;
         end
         default: begin
         end
      endcase
   endfunction

   function longint sine_of(longint p);
      longint q, idx, v;
      p   = p & (PHASE_STEPS - 1);
      q   = p >> 8;
      idx = p & (QUARTER - 1);
      v   = (q & 1) ? sine_q[QUARTER - idx] : sine_q[idx];
      return (q & 2) ? -v : v;
   endfunction

   // halves away from zero
   function longint shift15(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (1 << 14)) >> 15;
      return (v < 0) ? -m : m;
   endfunction

   function longint clamp_grid(longint v);
      if (v < 1) begin
         return 1;
      end
      return (v > 256) ? 256 : v;
   endfunction

   function mesh_result_type triangle(longint a, longint b, longint c);
      mesh_result_type t;
      t = '{default: '0};
      t.kind     = 1'b1;
      t.corner_a = a[16:0];
      t.corner_b = b[16:0];
      t.corner_c = c[16:0];
      return t;
   endfunction

   // work out the vertex and cell triangles of one accepted grid point
   function void note_point(logic [8:0] stack_in, logic [8:0] sector_in);
      longint          stacks, sectors, st, se, pphi, pth, ny, rr, nx, nz, u, v, k1, k2;
      mesh_result_type vert;
      stacks  = clamp_grid(stack_reg);
      sectors = clamp_grid(sector_reg);
      st = (stack_in > stacks) ? stacks : stack_in;
      se = (sector_in > sectors) ? sectors : sector_in;
      pphi = (st * PHASE_STEPS + stacks) / (2 * stacks);
      pth  = ((2 * se * PHASE_STEPS + sectors) / (2 * sectors)) & (PHASE_STEPS - 1);
      ny = sine_of(pphi + QUARTER);
      rr = sine_of(pphi);
      nx = shift15(rr * sine_of(pth + QUARTER));
      nz = shift15(rr * sine_of(pth));
      u  = (2 * se * 32768 + sectors) / (2 * sectors);
      v  = (2 * st * 32768 + stacks) / (2 * stacks);
      vert = '{default: '0};
      vert.pos_x  = 17'(shift15(radius_q88 * nx));
      vert.pos_y  = 17'(shift15(radius_q88 * ny));
      vert.pos_z  = 17'(shift15(radius_q88 * nz));
      vert.norm_x = 16'(nx);
      vert.norm_y = 16'(ny);
      vert.norm_z = 16'(nz);
      vert.tex_uv = {u[15:0], v[15:0]};
      pending_results.push_back(vert);
      if (st < stacks && se < sectors) begin
         k1 = st * (sectors + 1) + se;
         k2 = k1 + sectors + 1;
         // upper triangle missing on the top stack, lower on the bottom one
         if (st != 0) begin
            pending_results.push_back(triangle(k1, k2, k1 + 1));
         end
         if (st != stacks - 1) begin
            pending_results.push_back(triangle(k1 + 1, k2, k2 + 1));
         end
      end
      pending_results[pending_results.size() - 1].last = 1'b1;
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0h, want %0h", what, got, want);
      error_count++;
   endtask

   task check_result(mesh_result_type got);
      mesh_result_type w;
      if (pending_results.size() == 0) begin
         report("unexpected result", got.kind, 0);
         return;
      end
      w = pending_results.pop_front();
      if (got.kind !== w.kind) report("kind", got.kind, w.kind);
      if (got.last !== w.last) report("last", got.last, w.last);
      if (got.pos_x !== w.pos_x) report("pos_x", got.pos_x, w.pos_x);
      if (got.pos_y !== w.pos_y) report("pos_y", got.pos_y, w.pos_y);
      if (got.pos_z !== w.pos_z) report("pos_z", got.pos_z, w.pos_z);
      if (got.norm_x !== w.norm_x) report("norm_x", got.norm_x, w.norm_x);
      if (got.norm_y !== w.norm_y) report("norm_y", got.norm_y, w.norm_y);
      if (got.norm_z !== w.norm_z) report("norm_z", got.norm_z, w.norm_z);
      if (got.tex_uv !== w.tex_uv) report("tex_uv", got.tex_uv, w.tex_uv);
      if (got.corner_a !== w.corner_a) report("corner_a", got.corner_a, w.corner_a);
      if (got.corner_b !== w.corner_b) report("corner_b", got.corner_b, w.corner_b);
      if (got.corner_c !== w.corner_c) report("corner_c", got.corner_c, w.corner_c);
   endtask
endclass

module tb_uv_sphere_mesh_generator;
   import usmg_pkg::*;

   // index past the last register, the block must ignore it
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [COUNT_W-1:0]       req_stack_pos = '0;
   logic [COUNT_W-1:0]       req_sector_pos = '0;
   logic                     csr_write = 1'b0;
   logic [1:0]               csr_index = '0;
   logic [CSR_W-1:0]         csr_data = '0;
   logic                     rsp_valid;
   logic                     rsp_kind;
   logic                     rsp_last;
   logic signed [POS_W-1:0]  rsp_pos_x;
   logic signed [POS_W-1:0]  rsp_pos_y;
   logic signed [POS_W-1:0]  rsp_pos_z;
   logic signed [NORM_W-1:0] rsp_norm_x;
   logic signed [NORM_W-1:0] rsp_norm_y;
   logic signed [NORM_W-1:0] rsp_norm_z;
   logic [2*TEX_W-1:0]       rsp_tex_uv;
   logic [IDX_W-1:0]         rsp_corner_a;
   logic [IDX_W-1:0]         rsp_corner_b;
   logic [IDX_W-1:0]         rsp_corner_c;

   mesh_scoreboard sb = new();
   bit             no_gaps = 1'b0;   // long stretch with the sender never idling

   uv_sphere_mesh_generator u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // accepted transactions feed the predictor
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         sb.note_point(req_stack_pos, req_sector_pos);
      end
   end

   // results cannot be held off, so every strobe is checked
   always @(posedge clock) begin
      mesh_result_type r;
      if (!reset && rsp_valid) begin
         r.kind     = rsp_kind;
         r.last     = rsp_last;
         r.pos_x    = rsp_pos_x;
         r.pos_y    = rsp_pos_y;
         r.pos_z    = rsp_pos_z;
         r.norm_x   = rsp_norm_x;
         r.norm_y   = rsp_norm_y;
         r.norm_z   = rsp_norm_z;
         r.tex_uv   = rsp_tex_uv;
         r.corner_a = rsp_corner_a;
         r.corner_b = rsp_corner_b;
         r.corner_c = rsp_corner_c;
         sb.check_result(r);
      end
   end

   // start stays high across back-to-back points; a gap lowers it first
   task automatic send_point(int st, int se);
      if (!no_gaps && $urandom_range(99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start          <= 1'b1;
      req_stack_pos  <= st[8:0];
      req_sector_pos <= se[8:0];
      do @(posedge clock); while (busy);
   endtask

   // only called with the block idle; csr_write is lowered again after each write
   task automatic write_reg(logic [1:0] idx, int val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[15:0];
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending_results.size() > 0) @(posedge clock);
      // margin for the pipeline latency
      repeat (12) @(posedge clock);
   endtask

   // mostly points inside the grid, some anywhere in the field range
   task automatic random_points(int n);
      int stacks, sectors;
      for (int i = 0; i < n; i++) begin
         stacks  = int'(sb.clamp_grid(sb.stack_reg));
         sectors = int'(sb.clamp_grid(sb.sector_reg));
         if ($urandom_range(3) == 0) begin
            send_point($urandom_range(511), $urandom_range(511));
         end else begin
            send_point($urandom_range(stacks), $urandom_range(sectors));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults, 16 by 16, radius 1.0: poles, edges, clamped points
      send_point(0, 0);
      send_point(16, 16);
      send_point(511, 511);
      send_point(15, 0);
      send_point(1, 15);
      send_point(8, 4);
      send_point(0, 16);
      send_point(16, 0);
      send_point(15, 15);
      send_point(256, 3);
      send_point(7, 256);
      random_points(15);
      drain();

      // largest grid and radius, no gaps from the sender
      write_reg(CSR_RADIUS, 65535);
      write_reg(CSR_SECTOR_COUNT, 256);
      write_reg(CSR_STACK_COUNT, 256);
      write_reg(CSR_SPARE, 16'h5A5A);
      no_gaps = 1'b1;
      send_point(0, 0);
      send_point(255, 255);
      send_point(256, 256);
      send_point(128, 64);
      send_point(511, 0);
      random_points(30);
      no_gaps = 1'b0;
      drain();

      // zero counts act as one: single stack gives vertices only
      write_reg(CSR_RADIUS, 0);
      write_reg(CSR_SECTOR_COUNT, 0);
      write_reg(CSR_STACK_COUNT, 0);
      send_point(0, 0);
      send_point(1, 1);
      send_point(511, 511);
      random_points(10);
      drain();

      // oversized stack count clamps, three sectors
      write_reg(CSR_RADIUS, $urandom_range(65535));
      write_reg(CSR_SECTOR_COUNT, 3);
      write_reg(CSR_STACK_COUNT, 511);
      random_points(25);
      drain();

      // two stacks, random sector count
      write_reg(CSR_RADIUS, $urandom_range(65535));
      write_reg(CSR_SECTOR_COUNT, $urandom_range(1, 300));
      write_reg(CSR_STACK_COUNT, 2);
      random_points(15);
      drain();

      if (sb.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
